FILE: rtl/gcd_pkg.sv
package gcd_pkg;

   localparam int NUM_SLOTS  = 3;
   localparam int DATA_W     = 16;
   localparam int COMP_W     = 2;
   localparam int Q_W        = 19;   // r in Q3.16, below 8
   localparam int STEP_BITS  = 14;
   localparam int IDX_W      = Q_W - STEP_BITS;
   localparam int DENS_W     = 32;
   localparam int CSR_IDX_W  = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MEAN_0   = 3'd0,
      CSR_MEAN_1   = 3'd1,
      CSR_MEAN_2   = 3'd2,
      CSR_SPREAD_0 = 3'd3,
      CSR_SPREAD_1 = 3'd4,
      CSR_SPREAD_2 = 3'd5,
      CSR_COUNT    = 3'd6
   } csr_index_type;

   // exp(-r*r/2)/sqrt(2*pi) at r = k/4, UQ0.32
   function automatic logic [DENS_W-1:0] phi_value(input logic [IDX_W:0] k);
      logic [DENS_W-1:0] v;
      unique case (k)
         6'd0:  v = 32'd1713444050;
         6'd1:  v = 32'd1660726517;
         6'd2:  v = 32'd1512109062;
         6'd3:  v = 32'd1293376107;
         6'd4:  v = 32'd1039256448;
         6'd5:  v = 32'd784471230;
         6'd6:  v = 32'd556273038;
         6'd7:  v = 32'd370557978;
         6'd8:  v = 32'd231889475;
         6'd9:  v = 32'd136319895;
         6'd10: v = 32'd75283591;
         6'd11: v = 32'd39056244;
         6'd12: v = 32'd19034650;
         6'd13: v = 32'd8714748;
         6'd14: v = 32'd3748159;
         6'd15: v = 32'd1514394;
         6'd16: v = 32'd574792;
         6'd17: v = 32'd204945;
         6'd18: v = 32'd68650;
         6'd19: v = 32'd21602;
         6'd20: v = 32'd6385;
         6'd21: v = 32'd1773;
         6'd22: v = 32'd463;
         6'd23: v = 32'd113;
         6'd24: v = 32'd26;
         6'd25: v = 32'd6;
         6'd26: v = 32'd1;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

FILE: rtl/gcd_divider.sv
// Pipelined restoring divider, one quotient bit per stage.
// Caller guarantees in_rem < in_den.
module gcd_divider #(
   parameter int STEPS  = 19,
   parameter int DEN_W  = 16,
   parameter int SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DEN_W-1:0]  in_rem,
   input  logic [STEPS-1:0]  in_bits,
   input  logic [DEN_W-1:0]  in_den,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [STEPS-1:0]  out_quot,
   output logic [SIDE_W-1:0] out_side
);

   logic              s_valid [0:STEPS];
   logic [DEN_W-1:0]  s_rem   [0:STEPS];
   logic [STEPS-1:0]  s_bits  [0:STEPS];
   logic [STEPS-1:0]  s_quot  [0:STEPS];
   logic [DEN_W-1:0]  s_den   [0:STEPS];
   logic [SIDE_W-1:0] s_side  [0:STEPS];

   assign s_valid[0] = in_valid;
   assign s_rem[0]   = in_rem;
   assign s_bits[0]  = in_bits;
   assign s_quot[0]  = '0;
   assign s_den[0]   = in_den;
   assign s_side[0]  = in_side;

   for (genvar k = 0; k < STEPS; k++) begin : g_stage
      logic              valid_ff;
      logic [DEN_W-1:0]  rem_ff, rem_in;
      logic [STEPS-1:0]  bits_ff, quot_ff, quot_in;
      logic [DEN_W-1:0]  den_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [DEN_W:0]    trial;
      logic [DEN_W:0]    diff;
      logic              ge;

      always_comb begin
         trial   = {s_rem[k], s_bits[k][STEPS-1]};
         diff    = trial - {1'b0, s_den[k]};
         ge      = trial >= {1'b0, s_den[k]};
         rem_in  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quot_in = {s_quot[k][STEPS-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else begin
            valid_ff <= s_valid[k];
         end
         rem_ff  <= rem_in;
         bits_ff <= s_bits[k] << 1;
         quot_ff <= quot_in;
         den_ff  <= s_den[k];
         side_ff <= s_side[k];
      end

      assign s_valid[k+1] = valid_ff;
      assign s_rem[k+1]   = rem_ff;
      assign s_bits[k+1]  = bits_ff;
      assign s_quot[k+1]  = quot_ff;
      assign s_den[k+1]   = den_ff;
      assign s_side[k+1]  = side_ff;
   end

   assign out_valid = s_valid[STEPS];
   assign out_quot  = s_quot[STEPS];
   assign out_side  = s_side[STEPS];

endmodule

FILE: rtl/gaussian_component_density_core.sv
// Gaussian density per mixture component. A sample is taken when start is
// high and busy is low; it is then issued once per component in use (up to
// three), one per cycle, and busy is high while all but the last component are
// issued, so a new sample can be taken as the last component is issued. Each
// component runs through a fixed pipeline (offset and tail check, a 19-stage
// divider for r, table lookup and interpolation, a 32-stage divider by the
// spread, a result register), giving one result per cycle on rsp_* with
// rsp_strobe high for one cycle.
// Results cannot be held off: they must be captured in the cycle they appear.
// Registers may be written only while no sample is in flight.
module gaussian_component_density_core #(
   parameter int MAX_COMPONENTS = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [gcd_pkg::DATA_W-1:0]      req_intensity,
   output logic                            rsp_strobe,
   output logic [gcd_pkg::COMP_W-1:0]      rsp_component,
   output logic [gcd_pkg::DENS_W-1:0]      rsp_density,
   output logic                            rsp_last_component,
   input  logic                            csr_we,
   input  logic [gcd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [gcd_pkg::DATA_W-1:0]      csr_wdata
);

   localparam int DW = gcd_pkg::DATA_W;
   localparam int CW = gcd_pkg::COMP_W;
   localparam int QW = gcd_pkg::Q_W;
   localparam int SB = gcd_pkg::STEP_BITS;
   localparam int IW = gcd_pkg::IDX_W;
   localparam int OW = gcd_pkg::DENS_W;
   localparam int SIDE1_W = CW + 2 + DW;
   localparam int SIDE2_W = CW + 2;

   // configuration
   logic [DW-1:0] mean_ff   [gcd_pkg::NUM_SLOTS];
   logic [DW-1:0] spread_ff [gcd_pkg::NUM_SLOTS];
   logic [CW-1:0] count_ff;
   logic [CW-1:0] n_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < gcd_pkg::NUM_SLOTS; i++) begin
            mean_ff[i]   <= '0;
            spread_ff[i] <= DW'(1);
         end
         count_ff <= CW'(3);
      end else if (csr_we) begin
         unique case (csr_index)
            gcd_pkg::CSR_MEAN_0:   mean_ff[0]   <= csr_wdata;
            gcd_pkg::CSR_MEAN_1:   mean_ff[1]   <= csr_wdata;
            gcd_pkg::CSR_MEAN_2:   mean_ff[2]   <= csr_wdata;
            gcd_pkg::CSR_SPREAD_0: spread_ff[0] <= csr_wdata;
            gcd_pkg::CSR_SPREAD_1: spread_ff[1] <= csr_wdata;
            gcd_pkg::CSR_SPREAD_2: spread_ff[2] <= csr_wdata;
            gcd_pkg::CSR_COUNT:    count_ff     <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      n_eff = count_ff;
      if (n_eff == '0) n_eff = CW'(1);
      if (n_eff > CW'(MAX_COMPONENTS)) n_eff = CW'(MAX_COMPONENTS);
   end

   // issue: one component per cycle
   logic          iss_valid_ff, iss_valid_in;
   logic          iss_last_ff, iss_last_in;
   logic [CW-1:0] iss_comp_ff, iss_comp_in;
   logic [CW-1:0] iss_n_ff, iss_n_in;
   logic [DW-1:0] iss_y_ff, iss_y_in;
   logic          accept;

   assign busy   = iss_valid_ff && !iss_last_ff;
   assign accept = start && !busy;

   always_comb begin
      iss_valid_in = 1'b0;
      iss_last_in  = iss_last_ff;
      iss_comp_in  = iss_comp_ff;
      iss_n_in     = iss_n_ff;
      iss_y_in     = iss_y_ff;
      if (accept) begin
         iss_valid_in = 1'b1;
         iss_comp_in  = '0;
         iss_n_in     = n_eff;
         iss_y_in     = req_intensity;
         iss_last_in  = (n_eff == CW'(1));
      end else if (busy) begin
         iss_valid_in = 1'b1;
         iss_comp_in  = iss_comp_ff + CW'(1);
         iss_last_in  = (iss_comp_ff + CW'(2) == iss_n_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iss_valid_ff <= 1'b0;
         iss_last_ff  <= 1'b0;
      end else begin
         iss_valid_ff <= iss_valid_in;
         iss_last_ff  <= iss_last_in;
      end
      iss_comp_ff <= iss_comp_in;
      iss_n_ff    <= iss_n_in;
      iss_y_ff    <= iss_y_in;
   end

   // offset, spread and far-tail check
   logic          off_valid_ff;
   logic [DW-1:0] off_d_ff, off_d_in;
   logic [DW-1:0] off_sig_ff, off_sig_in;
   logic          off_far_ff, off_far_in;
   logic [CW-1:0] off_comp_ff;
   logic          off_last_ff;
   logic [DW-1:0] sel_mean;

   always_comb begin
      sel_mean   = mean_ff[iss_comp_ff];
      off_sig_in = spread_ff[iss_comp_ff];
      if (off_sig_in == '0) off_sig_in = DW'(1);
      off_d_in   = (iss_y_ff >= sel_mean) ? iss_y_ff - sel_mean : sel_mean - iss_y_ff;
      off_far_in = {3'b000, off_d_in} >= {off_sig_in, 3'b000};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_valid_ff <= 1'b0;
      end else begin
         off_valid_ff <= iss_valid_ff;
      end
      off_d_ff    <= off_d_in;
      off_sig_ff  <= off_sig_in;
      off_far_ff  <= off_far_in;
      off_comp_ff <= iss_comp_ff;
      off_last_ff <= iss_last_ff;
   end

   // r = (d << 16) / sigma, known below 8.0 when not in the far tail
   logic               r_valid;
   logic [QW-1:0]      r_quot;
   logic [SIDE1_W-1:0] r_side;

   gcd_divider #(
      .STEPS  (QW),
      .DEN_W  (DW),
      .SIDE_W (SIDE1_W)
   ) u_div_r (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (off_valid_ff),
      .in_rem    ({3'b000, off_d_ff[DW-1:3]}),
      .in_bits   ({off_d_ff[2:0], 16'h0000}),
      .in_den    (off_sig_ff),
      .in_side   ({off_comp_ff, off_last_ff, off_far_ff, off_sig_ff}),
      .out_valid (r_valid),
      .out_quot  (r_quot),
      .out_side  (r_side)
   );

   // table lookup
   logic          lut_valid_ff;
   logic [OW-1:0] lut_hi_ff, lut_diff_ff;
   logic [SB-1:0] lut_frac_ff;
   logic [SIDE1_W-1:0] lut_side_ff;
   logic [IW-1:0] lut_idx;
   logic [OW-1:0] lut_hi_in, lut_lo;

   always_comb begin
      lut_idx   = r_quot[QW-1:SB];
      lut_hi_in = gcd_pkg::phi_value({1'b0, lut_idx});
      lut_lo    = gcd_pkg::phi_value({1'b0, lut_idx} + (IW+1)'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lut_valid_ff <= 1'b0;
      end else begin
         lut_valid_ff <= r_valid;
      end
      lut_hi_ff   <= lut_hi_in;
      lut_diff_ff <= lut_hi_in - lut_lo;
      lut_frac_ff <= r_quot[SB-1:0];
      lut_side_ff <= r_side;
   end

   // interpolation product
   logic             mul_valid_ff;
   logic [OW+SB-1:0] mul_prod_ff;
   logic [OW-1:0]    mul_hi_ff;
   logic [SIDE1_W-1:0] mul_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= lut_valid_ff;
      end
      mul_prod_ff <= lut_diff_ff * lut_frac_ff;
      mul_hi_ff   <= lut_hi_ff;
      mul_side_ff <= lut_side_ff;
   end

   // interpolated value plus half spread for rounding
   logic             num_valid_ff;
   logic [OW-1:0]    num_ff, num_in;
   logic [DW-1:0]    num_sig_ff;
   logic [SIDE2_W-1:0] num_side_ff;
   logic [OW+SB-1:0] rounded;

   always_comb begin
      rounded = mul_prod_ff + (OW+SB)'(1 << (SB - 1));
      num_in  = mul_hi_ff - OW'(rounded >> SB)
              + {{(OW-DW+1){1'b0}}, mul_side_ff[DW-1:1]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else begin
         num_valid_ff <= mul_valid_ff;
      end
      num_ff      <= num_in;
      num_sig_ff  <= mul_side_ff[DW-1:0];
      num_side_ff <= mul_side_ff[SIDE1_W-1:DW];
   end

   // divide by spread
   logic               q_valid;
   logic [OW-1:0]      q_quot;
   logic [SIDE2_W-1:0] q_side;

   gcd_divider #(
      .STEPS  (OW),
      .DEN_W  (DW),
      .SIDE_W (SIDE2_W)
   ) u_div_s (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (num_valid_ff),
      .in_rem    ('0),
      .in_bits   (num_ff),
      .in_den    (num_sig_ff),
      .in_side   (num_side_ff),
      .out_valid (q_valid),
      .out_quot  (q_quot),
      .out_side  (q_side)
   );

   // result register
   logic          rsp_strobe_ff;
   logic [CW-1:0] rsp_comp_ff;
   logic [OW-1:0] rsp_dens_ff;
   logic          rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= q_valid;
      end
      rsp_comp_ff <= q_side[SIDE2_W-1:2];
      rsp_last_ff <= q_side[1];
      rsp_dens_ff <= q_side[0] ? '0 : q_quot;
   end

   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_component      = rsp_comp_ff;
   assign rsp_density        = rsp_dens_ff;
   assign rsp_last_component = rsp_strobe_ff && rsp_last_ff;

`ifndef SYNTHESIS
   a_comp_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && $past(rsp_strobe) && !$past(rsp_last_component)
      |-> rsp_component == $past(rsp_component) + CW'(1))
      else $error("component sequence broken");

   a_single_no_busy: assert property (@(posedge clock) disable iff (reset)
      accept && n_eff == CW'(1) |=> !busy)
      else $error("busy after single-component sample");

   a_busy_issue: assert property (@(posedge clock) disable iff (reset)
      busy |-> iss_valid_ff && iss_comp_ff + CW'(1) < iss_n_ff)
      else $error("busy without pending component");
`endif

endmodule

FILE: tb/tb_gaussian_component_density_core.sv
module tb_gaussian_component_density_core;

   localparam int CSR_W = gcd_pkg::CSR_IDX_W;
   localparam int CMP_W = gcd_pkg::COMP_W;
   localparam int DEN_W = gcd_pkg::DENS_W;
   localparam int NSLOT = gcd_pkg::NUM_SLOTS;
   localparam logic [CSR_W-1:0] CSR_UNUSED = 3'd7;
   localparam int DRAIN_CYCLES = 80;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic [CMP_W-1:0] component;
      logic [DEN_W-1:0] density;
      logic             last;
   } density_result_type;

   // phi(r) = exp(-r*r/2)/sqrt(2*pi) at r = k/4, UQ0.32
   localparam logic [31:0] PHI_TAB [0:32] = '{
      32'd1713444050, 32'd1660726517, 32'd1512109062, 32'd1293376107,
      32'd1039256448, 32'd784471230,  32'd556273038,  32'd370557978,
      32'd231889475,  32'd136319895,  32'd75283591,   32'd39056244,
      32'd19034650,   32'd8714748,    32'd3748159,    32'd1514394,
      32'd574792,     32'd204945,     32'd68650,      32'd21602,
      32'd6385,       32'd1773,       32'd463,        32'd113,
      32'd26,         32'd6,          32'd1,          32'd0,
      32'd0,          32'd0,          32'd0,          32'd0,
      32'd0
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [gcd_pkg::DATA_W-1:0] req_intensity = '0;
   logic rsp_strobe;
   logic [CMP_W-1:0] rsp_component;
   logic [DEN_W-1:0] rsp_density;
   logic rsp_last_component;
   logic csr_we = 1'b0;
   logic [CSR_W-1:0] csr_index = '0;
   logic [gcd_pkg::DATA_W-1:0] csr_wdata = '0;

   gaussian_component_density_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow registers
   logic [15:0] mean_q [NSLOT];
   logic [15:0] spread_q [NSLOT];
   logic [1:0]  count_q;

   density_result_type pending_densities [$];
   int mismatches = 0;
   int samples_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   bit idling_on = 1'b1;

   function automatic logic [31:0] gauss_density(logic [15:0] y, logic [15:0] mu,
                                                 logic [15:0] sig_in);
      logic [63:0] sig, d, r, idx, frac, hi, lo, v;
      sig = (sig_in == 0) ? 64'd1 : 64'(sig_in);
      d = (y >= mu) ? 64'(y - mu) : 64'(mu - y);
      if (d >= 8 * sig) return '0;
      r = (d << 16) / sig;
      idx = r >> 14;
      if (idx >= 32) idx = 31;
      frac = r & 64'h3fff;
      hi = PHI_TAB[idx];
      lo = PHI_TAB[idx + 1];
      v = hi - (((hi - lo) * frac + 64'd8192) >> 14);
      return 32'((v + (sig >> 1)) / sig);
   endfunction

   function automatic void predict_sample(logic [15:0] y);
      int n;
      density_result_type e;
      n = (count_q == 0) ? 1 : ((count_q > NSLOT) ? NSLOT : count_q);
      for (int c = 0; c < n; c++) begin
         e.component = CMP_W'(c);
         e.density = gauss_density(y, mean_q[c], spread_q[c]);
         e.last = (c + 1 == n);
         pending_densities.push_back(e);
      end
   endfunction

   task automatic drain();
      while (pending_densities.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      if (idx < gcd_pkg::CSR_SPREAD_0) mean_q[idx[1:0]] = val;
      else if (idx < gcd_pkg::CSR_COUNT) spread_q[2'(idx - gcd_pkg::CSR_SPREAD_0)] = val;
      else if (idx == gcd_pkg::CSR_COUNT) count_q = val[1:0];
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic send_sample(logic [15:0] y);
      bit taken;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         start = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      start = 1'b1;
      req_intensity = y;
      taken = 1'b0;
      while (!taken) begin
         taken = !busy;
         if (taken) predict_sample(y);
         @(posedge clock);
         @(negedge clock);
      end
      start = 1'b0;
      samples_sent++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         density_result_type got, want;
         got = '{rsp_component, rsp_density, rsp_last_component};
         results_seen++;
         if (pending_densities.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: comp %0d dens %0d last %0b",
                        got.component, got.density, got.last);
         end else begin
            want = pending_densities.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp comp %0d dens %0d last %0b, got %0d %0d %0b",
                           want.component, want.density, want.last,
                           got.component, got.density, got.last);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   task automatic test_reset_defaults();
      send_sample(16'd0);
      send_sample(16'd1);
      send_sample(16'd7);
      send_sample(16'd8);
      send_sample(16'hffff);
   endtask

   task automatic test_extremes();
      drain();
      write_reg(gcd_pkg::CSR_MEAN_0, 16'd0);
      write_reg(gcd_pkg::CSR_MEAN_1, 16'hffff);
      write_reg(gcd_pkg::CSR_MEAN_2, 16'd32768);
      write_reg(gcd_pkg::CSR_SPREAD_0, 16'hffff);
      write_reg(gcd_pkg::CSR_SPREAD_1, 16'd0);   // zero spread acts as one
      write_reg(gcd_pkg::CSR_SPREAD_2, 16'd1000);
      write_reg(CSR_UNUSED, 16'h5a5a);           // ignored
      send_sample(16'd0);
      send_sample(16'hffff);
      send_sample(16'd32768);
      send_sample(16'd40768);                    // tail edge on slot 2
      send_sample(16'd40767);
      send_sample(16'd24768);
      send_sample(16'hfff8);
      drain();
      write_reg(gcd_pkg::CSR_COUNT, 16'd0);      // acts as one
      send_sample(16'd12345);
      drain();
      write_reg(gcd_pkg::CSR_COUNT, 16'd1);
      send_sample(16'd100);
      drain();
      write_reg(gcd_pkg::CSR_COUNT, 16'd2);
      send_sample(16'd65000);
      send_sample(16'd1);
      drain();
      write_reg(gcd_pkg::CSR_COUNT, 16'd3);
   endtask

   task automatic test_random(int phases, int per_phase);
      logic [15:0] y, off, sig;
      int c;
      for (int p = 0; p < phases; p++) begin
         drain();
         for (int i = 0; i < NSLOT; i++) begin
            write_reg(CSR_W'(gcd_pkg::CSR_MEAN_0 + i), 16'($urandom));
            case ($urandom_range(0, 3))
               0: sig = 16'($urandom);
               1: sig = 16'($urandom_range(0, 4));
               default: sig = 16'($urandom_range(1, 3000));
            endcase
            write_reg(CSR_W'(gcd_pkg::CSR_SPREAD_0 + i), sig);
         end
         write_reg(gcd_pkg::CSR_COUNT, 16'($urandom));
         if (p == phases - 1) idling_on = 1'b0;
         for (int k = 0; k < per_phase; k++) begin
            if (k == per_phase / 2 && p == 1) drain();
            c = $urandom_range(0, NSLOT - 1);
            if ($urandom_range(0, 4) == 0) y = 16'($urandom);
            else begin
               sig = (spread_q[c] == 0) ? 16'd1 : spread_q[c];
               off = 16'($urandom_range(0, 9 * 32'(sig)));
               y = $urandom_range(0, 1) ? mean_q[c] + off : mean_q[c] - off;
            end
            send_sample(y);
         end
      end
   endtask

   initial begin
      for (int i = 0; i < NSLOT; i++) begin
         mean_q[i] = '0;
         spread_q[i] = 16'd1;
      end
      count_q = 2'd3;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_extremes();
      test_random(6, 72);
      drain();
      $display("covered %0d samples, %0d component densities, random register sets",
               samples_sent, results_seen);
      $display("with tail, zero spread and component count corner cases");
      if (mismatches == 0 && pending_densities.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches, %0d left over", mismatches, pending_densities.size());
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
rtl/gcd_pkg.sv
rtl/gcd_divider.sv
rtl/gaussian_component_density_core.sv
tb/tb_gaussian_component_density_core.sv
